@@ hw/rtl/pulse_dial_digit_decoder_assert.svh @@
// Assertion macros for the pulse dial digit decoder.
// Included by the RTL files that check their own logic; no other dependencies.
// Defining NO_ASSERTIONS leaves every macro empty.
`ifndef PULSE_DIAL_DIGIT_DECODER_ASSERT_SVH
`define PULSE_DIAL_DIGIT_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held
`define PDDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pulse dial decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define PDDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pulse dial decoder: next-cycle check failed");

`else

`define PDDD_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define PDDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/pddd_pkg.sv @@
// Shared types and constants for the pulse dial digit decoder.
// No dependencies; used by pddd_cfg_regs, pddd_step and the top level.
`timescale 1ns / 1ps

package pddd_pkg;

    localparam int CFG_BITS   = 16;
    localparam int DIGIT_BITS = 4;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DIGIT_GAP = 2'd0;
    localparam logic [1:0] REG_END_GAP   = 2'd1;
    localparam logic [1:0] REG_MAX_PULSE = 2'd2;

    // Reset values of the timing registers, in milliseconds
    localparam logic [CFG_BITS-1:0] RST_DIGIT_GAP = 16'd100;
    localparam logic [CFG_BITS-1:0] RST_END_GAP   = 16'd210;
    localparam logic [CFG_BITS-1:0] RST_MAX_PULSE = 16'd60;

    // Pulse count wraps after nine back to zero (modulo ten)
    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [CFG_BITS-1:0] digit_gap;
        logic [CFG_BITS-1:0] end_gap;
        logic [CFG_BITS-1:0] max_pulse;
    } t_cfg;

    typedef struct packed {
        logic                  emit;
        logic [DIGIT_BITS-1:0] digit;
        logic                  pulse_error;
        logic                  end_of_number;
    } t_result;

endpackage

@@ hw/rtl/pddd_cfg_regs.sv @@
// APB register file holding the three timing limits of the decoder.
// Depends on pddd_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module pddd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pddd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pddd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pddd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output pddd_pkg::t_cfg                    o_cfg
);

    pddd_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digit_gap <= pddd_pkg::RST_DIGIT_GAP;
            r_cfg.end_gap   <= pddd_pkg::RST_END_GAP;
            r_cfg.max_pulse <= pddd_pkg::RST_MAX_PULSE;
        end else if (wr_en) begin
            unique case (reg_idx)
                pddd_pkg::REG_DIGIT_GAP: r_cfg.digit_gap <= pwdata[pddd_pkg::CFG_BITS-1:0];
                pddd_pkg::REG_END_GAP:   r_cfg.end_gap   <= pwdata[pddd_pkg::CFG_BITS-1:0];
                pddd_pkg::REG_MAX_PULSE: r_cfg.max_pulse <= pwdata[pddd_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            pddd_pkg::REG_DIGIT_GAP: prdata = pddd_pkg::APB_DATA_W'(r_cfg.digit_gap);
            pddd_pkg::REG_END_GAP:   prdata = pddd_pkg::APB_DATA_W'(r_cfg.end_gap);
            pddd_pkg::REG_MAX_PULSE: prdata = pddd_pkg::APB_DATA_W'(r_cfg.max_pulse);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/pddd_step.sv @@
// Edge detection and gap timing for one line sample: next state and result.
// Depends on pddd_pkg for t_cfg, t_result and the digit constants.
`timescale 1ns / 1ps

module pddd_step #(
    parameter int TIME_BITS = 16
) (
    input  logic                              i_level,
    input  logic [TIME_BITS-1:0]              i_now,
    input  pddd_pkg::t_cfg                    i_cfg,
    input  logic                              i_last_level,
    input  logic [TIME_BITS-1:0]              i_last_edge,
    input  logic [pddd_pkg::DIGIT_BITS-1:0]   i_count,
    input  logic                              i_error_seen,
    output logic                              o_edge,
    output logic [pddd_pkg::DIGIT_BITS-1:0]   o_count,
    output logic                              o_error_seen,
    output pddd_pkg::t_result                 o_result
);

    // Compare width covers both the time and the register width
    localparam int CW = (TIME_BITS > pddd_pkg::CFG_BITS) ? TIME_BITS : pddd_pkg::CFG_BITS;

    logic                 rise;
    logic                 fall;
    logic [TIME_BITS-1:0] elapsed;
    logic [CW-1:0]        el_x;
    logic [CW-1:0]        dgap_x;
    logic [CW-1:0]        egap_x;
    logic [CW-1:0]        maxp_x;
    logic                 closes;

    assign rise    = i_level && !i_last_level;
    assign fall    = !i_level && i_last_level;
    assign o_edge  = rise || fall;

    // Wrapping interval since the last edge
    assign elapsed = i_now - i_last_edge;
    assign el_x    = CW'(elapsed);
    assign dgap_x  = CW'(i_cfg.digit_gap);
    assign egap_x  = CW'(i_cfg.end_gap);
    assign maxp_x  = CW'(i_cfg.max_pulse);
    assign closes  = rise && (el_x >= dgap_x);

    // Result for a closing gap
    assign o_result.emit          = closes;
    assign o_result.digit         = i_count;
    assign o_result.pulse_error   = i_error_seen;
    assign o_result.end_of_number = el_x > egap_x;

    // Count and error flag: cleared on emit, advanced on a falling edge
    always_comb begin
        o_count      = i_count;
        o_error_seen = i_error_seen;
        if (closes) begin
            o_count      = '0;
            o_error_seen = 1'b0;
        end else if (fall) begin
            o_count      = (i_count == pddd_pkg::DIGIT_MAX) ? '0 : i_count + 1'b1;
            o_error_seen = i_error_seen || (el_x >= maxp_x);
        end
    end

endmodule

@@ hw/rtl/pulse_dial_digit_decoder.sv @@
// Top level of the rotary dial pulse decoder: stream ports, state, result register.
// Depends on pddd_pkg, pddd_cfg_regs, pddd_step and pulse_dial_digit_decoder_assert.svh.
//
// Usage:
//   Line samples arrive on the s_axis channel, one sample per transfer, each
//   carrying the line level and a free-running millisecond timestamp. A falling
//   edge counts one dial pulse (modulo ten); a rising edge after a low gap of at
//   least digit_gap_ms closes the digit and produces one transfer on m_axis:
//   the digit in tdata, the too-wide-pulse flag in tuser, and tlast set when the
//   gap exceeded end_gap_ms (end of the dialled number). Other samples produce
//   nothing. The user sets timing limits over the APB port only while idle; the
//   block does not enforce it. m_axis shows a result in the cycle after the
//   closing sample. Throughput: one sample per cycle if not stalled; all the work is
//   one compare stage between the state registers and a single output register.
//   Stall: while a result waits with m_axis_tready low, s_axis_tready drops;
//   samples that produce no result are still taken whenever the register is free
//   or being emptied in the same cycle.
//   Reset: the line counts as low since time zero, count and error are cleared
//   and the limits return to 100, 210 and 60 ms.
`timescale 1ns / 1ps

`include "pulse_dial_digit_decoder_assert.svh"

module pulse_dial_digit_decoder #(
    parameter int TIME_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pddd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pddd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pddd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Sample stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // [0] line_level, [16:1] now_ms
    // Digit stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [3:0] digit
    output logic                              m_axis_tuser,  // [0] pulse_error
    output logic                              m_axis_tlast   // end_of_number
);

    pddd_pkg::t_cfg                  cfg;
    pddd_pkg::t_result               step_res;

    logic                            r_last_level;
    logic [TIME_BITS-1:0]            r_last_edge;
    logic [pddd_pkg::DIGIT_BITS-1:0] r_count;
    logic                            r_error_seen;

    logic                            r_m_valid;
    logic [pddd_pkg::DIGIT_BITS-1:0] r_digit;
    logic                            r_pulse_error;
    logic                            r_end_of_number;

    logic                            in_level;
    logic [TIME_BITS-1:0]            in_now;
    logic                            s_xfer;
    logic                            step_edge;
    logic [pddd_pkg::DIGIT_BITS-1:0] n_count;
    logic                            n_error_seen;

    pddd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Unpack the sample; timestamp taken modulo 2^TIME_BITS
    assign in_level = s_axis_tdata[0];
    assign in_now   = TIME_BITS'(s_axis_tdata[16:1]);

    pddd_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_level      (in_level),
        .i_now        (in_now),
        .i_cfg        (cfg),
        .i_last_level (r_last_level),
        .i_last_edge  (r_last_edge),
        .i_count      (r_count),
        .i_error_seen (r_error_seen),
        .o_edge       (step_edge),
        .o_count      (n_count),
        .o_error_seen (n_error_seen),
        .o_result     (step_res)
    );

    // Take a sample whenever the output register is free or draining
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_last_edge  <= '0;
            r_count      <= '0;
            r_error_seen <= 1'b0;
        end else if (s_xfer) begin
            r_last_level <= in_level;
            r_count      <= n_count;
            r_error_seen <= n_error_seen;
            if (step_edge) begin
                r_last_edge <= in_now;
            end
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_xfer && step_res.emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (s_xfer && step_res.emit) begin
            r_digit         <= step_res.digit;
            r_pulse_error   <= step_res.pulse_error;
            r_end_of_number <= step_res.end_of_number;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = 8'(r_digit);
    assign m_axis_tuser  = r_pulse_error;
    assign m_axis_tlast  = r_end_of_number;

    // Checks on the decoder's own logic
    `PDDD_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= pddd_pkg::DIGIT_MAX)
    `PDDD_ASSERT_NOW(a_digit_range, i_clk, i_rst_n, r_m_valid, r_digit <= pddd_pkg::DIGIT_MAX)
    `PDDD_ASSERT_NEXT(a_level_follows, i_clk, i_rst_n, s_xfer, r_last_level == $past(in_level))
    `PDDD_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, s_xfer && step_res.emit, m_axis_tvalid)
    `PDDD_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, s_xfer && step_res.emit, r_count == '0 && !r_error_seen)

endmodule

@@ bench/pulse_dial_digit_decoder_tb.sv @@
// Self-checking bench for the rotary dial pulse decoder: stream and APB stimulus,
// a cycle-free digit predictor and a scoreboard. Depends on pddd_pkg and the RTL.
`timescale 1ns / 1ps

module pulse_dial_digit_decoder_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int N_PHASES      = 8;
    localparam int N_SCRIPT      = 18;
    localparam int MAX_NOTES     = 30;

    // One scripted line sample; want is only used where typed is set
    typedef struct packed {
        logic              level;
        logic [15:0]       stamp;
        logic              typed;
        pddd_pkg::t_result want;
    } t_dir_row;

    typedef struct {
        logic [pddd_pkg::CFG_BITS-1:0] digit_gap;
        logic [pddd_pkg::CFG_BITS-1:0] end_gap;
        logic [pddd_pkg::CFG_BITS-1:0] max_pulse;
        int                            n_samples;
    } t_timing_plan;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pddd_pkg::APB_ADDR_W-1:0] paddr;
    logic [pddd_pkg::APB_DATA_W-1:0] pwdata;
    logic [pddd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [23:0]                     s_axis_tdata;   // [0] line_level, [16:1] now_ms
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [7:0]                      m_axis_tdata;   // [3:0] digit
    logic                            m_axis_tuser;   // [0] pulse_error
    logic                            m_axis_tlast;   // end_of_number

    // Predictor state and its copy of the timing registers
    pddd_pkg::t_cfg    dial_cfg;
    logic              line_high;
    logic [15:0]       line_edge_ms;
    logic [3:0]        pulse_cnt;
    logic              err_seen;
    pddd_pkg::t_result pending_digits[$];

    // Bench bookkeeping
    logic [15:0]     clock_ms;
    logic            tx_level;
    bit              tx_quiet;
    bit              rx_quiet;
    bit              hold_req;
    int              samples_sent;
    int              digits_seen;
    int              settings_loaded;
    int              mismatches;
    int              quiet_cycles;

    // Script: reset values 100/210/60 ms, wrapped stamps and the exact limits
    t_dir_row dial_script [N_SCRIPT] = '{
        {1'b1, 16'd150,   1'b1, 1'b1, 4'd0, 1'b0, 1'b0},  // first sample high, empty digit
        {1'b1, 16'd160,   1'b1, 1'b0, 4'd0, 1'b0, 1'b0},  // no edge
        {1'b0, 16'd200,   1'b0, 7'd0},
        {1'b1, 16'd250,   1'b1, 1'b0, 4'd0, 1'b0, 1'b0},  // short gap keeps the count
        {1'b0, 16'd310,   1'b0, 7'd0},                    // high time at the limit
        {1'b1, 16'd311,   1'b0, 7'd0},
        {1'b0, 16'd320,   1'b0, 7'd0},
        {1'b1, 16'd531,   1'b1, 1'b1, 4'd3, 1'b1, 1'b1},  // gap just over end gap
        {1'b0, 16'd65500, 1'b0, 7'd0},
        {1'b1, 16'd65535, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0},
        {1'b0, 16'd10,    1'b0, 7'd0},                    // timestamp wraps
        {1'b1, 16'd220,   1'b1, 1'b1, 4'd2, 1'b1, 1'b0},  // gap equal to end gap
        {1'b0, 16'd0,     1'b0, 7'd0},
        {1'b1, 16'd211,   1'b1, 1'b1, 4'd1, 1'b1, 1'b1},
        {1'b0, 16'd250,   1'b0, 7'd0},
        {1'b1, 16'd349,   1'b1, 1'b0, 4'd0, 1'b0, 1'b0},  // one below digit gap
        {1'b0, 16'd350,   1'b0, 7'd0},
        {1'b1, 16'd450,   1'b1, 1'b1, 4'd2, 1'b0, 1'b0}   // gap equal to digit gap
    };

    t_timing_plan timing_plan [N_PHASES];

    pulse_dial_digit_decoder #(
        .TIME_BITS(16)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_NOTES)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Edge detection and digit closing for one accepted sample
    function automatic bit decode_sample(input logic level, input logic [15:0] now,
                                         output pddd_pkg::t_result res);
        logic [15:0] elapsed;
        elapsed = now - line_edge_ms;
        res = '0;
        if (level && !line_high) begin
            line_high = 1'b1;
            if (elapsed >= dial_cfg.digit_gap) begin
                res.emit          = 1'b1;
                res.digit         = pulse_cnt;
                res.pulse_error   = err_seen;
                res.end_of_number = (elapsed > dial_cfg.end_gap);
                pulse_cnt = '0;
                err_seen  = 1'b0;
            end
            line_edge_ms = now;
        end else if (!level && line_high) begin
            line_high = 1'b0;
            pulse_cnt = (pulse_cnt == pddd_pkg::DIGIT_MAX) ? '0 : pulse_cnt + 4'd1;
            if (elapsed >= dial_cfg.max_pulse)
                err_seen = 1'b1;
            line_edge_ms = now;
        end
        return res.emit;
    endfunction

    // Offer one sample; queue the typed result if given, else the predicted one
    task automatic send_sample(input logic level, input logic [15:0] stamp,
                               input logic typed, input pddd_pkg::t_result typed_res);
        int                gap;
        pddd_pkg::t_result res;
        bit                emit;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, stamp, level};
        do @(posedge i_clk); while (!s_axis_tready);
        emit = decode_sample(level, stamp, res);
        if (typed) begin
            if (typed_res.emit)
                pending_digits.push_back(typed_res);
        end else if (emit) begin
            pending_digits.push_back(res);
        end
        tx_level = level;
        clock_ms = stamp;
        samples_sent++;
    endtask

    task automatic send_delta(input logic level, input int delta);
        send_sample(level, clock_ms + 16'(delta), 1'b0, '0);
    endtask

    // Stop offering and wait until every digit has come and the block is quiet
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write (setup, access) then read back, then psel is dropped
    task automatic set_timing_reg(input logic [1:0] idx,
                                  input logic [pddd_pkg::CFG_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(pddd_pkg::APB_DATA_W-pddd_pkg::CFG_BITS){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(pddd_pkg::APB_DATA_W-pddd_pkg::CFG_BITS){1'b0}}, val})
            mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_timing(input t_timing_plan plan);
        set_timing_reg(pddd_pkg::REG_DIGIT_GAP, plan.digit_gap);
        set_timing_reg(pddd_pkg::REG_END_GAP,   plan.end_gap);
        set_timing_reg(pddd_pkg::REG_MAX_PULSE, plan.max_pulse);
        dial_cfg.digit_gap = plan.digit_gap;
        dial_cfg.end_gap   = plan.end_gap;
        dial_cfg.max_pulse = plan.max_pulse;
        settings_loaded++;
    endtask

    // Interval a couple of ms either side of a limit, clamped to the stamp range
    function automatic int near_ms(input int thr);
        int v;
        v = thr + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    function automatic int around_ms(input int thr);
        if (thr == 0 || $urandom_range(0, 1) == 0)
            return near_ms(thr);
        return $urandom_range(0, thr - 1);
    endfunction

    // One dialled digit: pulses, breaks near or under digit_gap (random if broken), closing gap
    task automatic dial_digit(input bit broken);
        int n_pulses;
        int gap;
        if (!tx_level)
            send_delta(1'b1, near_ms(int'(dial_cfg.end_gap)));
        n_pulses = $urandom_range(1, 12);
        for (int k = 1; k <= n_pulses; k++) begin
            send_delta(1'b0, broken ? $urandom_range(0, 65535)
                                    : around_ms(int'(dial_cfg.max_pulse)));
            if (k < n_pulses)
                gap = broken ? $urandom_range(0, 65535) : around_ms(int'(dial_cfg.digit_gap));
            else begin
                case ($urandom_range(0, 2))
                    0:       gap = near_ms(int'(dial_cfg.end_gap));
                    1:       gap = near_ms(int'(dial_cfg.digit_gap));
                    default: gap = $urandom_range(int'(dial_cfg.digit_gap), 65535);
                endcase
            end
            send_delta(1'b1, gap);
        end
    endtask

    // Scoreboard on the digit stream
    always @(posedge i_clk) begin : digit_check
        pddd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            digits_seen++;
            if (pending_digits.size() == 0) begin
                mismatch($sformatf("digit %0d transfer with nothing pending", m_axis_tdata));
            end else begin
                want = pending_digits.pop_front();
                if (m_axis_tdata !== {4'h0, want.digit})
                    mismatch($sformatf("digit: got %0d, want %0d", m_axis_tdata, want.digit));
                if (m_axis_tuser !== want.pulse_error)
                    mismatch($sformatf("pulse_error: got %b, want %b",
                                       m_axis_tuser, want.pulse_error));
                if (m_axis_tlast !== want.end_of_number)
                    mismatch($sformatf("end_of_number: got %b, want %b",
                                       m_axis_tlast, want.end_of_number));
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold on request
    initial begin : digit_sink
        int pause;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            pause = rx_quiet ? 0 : $urandom_range(0, 7);
            if (pause != 0) begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int  phase_start;
        bit  paused;
        int  n_noise;
        line_high       = 1'b0;
        line_edge_ms    = '0;
        pulse_cnt       = '0;
        err_seen        = 1'b0;
        dial_cfg        = {pddd_pkg::RST_DIGIT_GAP, pddd_pkg::RST_END_GAP,
                           pddd_pkg::RST_MAX_PULSE};
        clock_ms        = '0;
        tx_level        = 1'b0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        hold_req        = 1'b0;
        samples_sent    = 0;
        digits_seen     = 0;
        settings_loaded = 0;
        mismatches      = 0;
        quiet_cycles    = 0;

        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Scripted samples at the reset timing
        for (int r = 0; r < N_SCRIPT; r++)
            send_sample(dial_script[r].level, dial_script[r].stamp,
                        dial_script[r].typed, dial_script[r].want);
        settle_idle();

        // Timing settings: reset, all zero, all ones, crossed limits, typical, random, reset again
        timing_plan[0] = '{pddd_pkg::RST_DIGIT_GAP, pddd_pkg::RST_END_GAP,
                           pddd_pkg::RST_MAX_PULSE, 170};
        timing_plan[1] = '{16'd0, 16'd0, 16'd0, 100};
        timing_plan[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 90};
        timing_plan[3] = '{16'd300, 16'd50, 16'd100, 120};
        timing_plan[4] = '{16'd40, 16'd120, 16'd30, 120};
        timing_plan[5] = '{16'($urandom_range(0, 400)), 16'($urandom_range(0, 600)),
                           16'($urandom_range(0, 150)), 140};
        timing_plan[6] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 60};
        timing_plan[7] = '{pddd_pkg::RST_DIGIT_GAP, pddd_pkg::RST_END_GAP,
                           pddd_pkg::RST_MAX_PULSE, 80};

        for (int p = 0; p < N_PHASES; p++) begin
            load_timing(timing_plan[p]);
            if (p == 0) begin
                // fill the block while the receiver holds off
                hold_req = 1'b1;
                tx_quiet = 1'b1;
            end
            phase_start = samples_sent;
            paused      = 1'b0;
            while (samples_sent - phase_start < timing_plan[p].n_samples) begin
                if (p == 3 && !paused
                        && samples_sent - phase_start >= timing_plan[p].n_samples / 2) begin
                    settle_idle();
                    paused = 1'b1;
                end
                if (!hold_req && $urandom_range(0, 5) == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                case ($urandom_range(0, 9))
                    7: begin
                        n_noise = $urandom_range(1, 4);
                        repeat (n_noise)
                            send_sample(1'($urandom_range(0, 1)),
                                        16'($urandom_range(0, 65535)), 1'b0, '0);
                    end
                    8:       send_delta(tx_level, $urandom_range(0, 300));
                    9:       dial_digit(1'b1);
                    default: dial_digit(1'b0);
                endcase
            end
            settle_idle();
        end

        // Drain and let the pipeline go quiet
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_digits.size() != 0)
            mismatch($sformatf("%0d digits never arrived", pending_digits.size()));

        $display("Run covered %0d line samples and %0d decoded digits over %0d timing settings,",
                 samples_sent, digits_seen, settings_loaded);
        $display("including wrapped stamps, crossed limits and a long output stall.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pddd_pkg.sv
hw/rtl/pddd_cfg_regs.sv
hw/rtl/pddd_step.sv
hw/rtl/pulse_dial_digit_decoder.sv
bench/pulse_dial_digit_decoder_tb.sv
